// ----- rtl/core/aig_and_node_strash_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef AIG_AND_NODE_STRASH_UNIT_DEFINES_SVH
`define AIG_AND_NODE_STRASH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AIGS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aigs assertion failed");

// Next-cycle implication, disabled during reset.
`define AIGS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aigs assertion failed");

`endif

// ----- rtl/core/aigs_pkg.sv -----
// Package: payload types, table entry type, state codes and status codes.
package aigs_pkg;

  localparam int LIT_W  = 17;
  localparam int NODE_W = 16;
  localparam int KEY_W  = 34;
  localparam int LITERAL_NODE_CAP = 65536;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NODE_FULL = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

  localparam logic CMD_INPUT = 1'b0;
  localparam logic CMD_AND   = 1'b1;

  localparam logic REG_SIMPLIFY = 1'b0;
  localparam logic REG_HASHING  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [LIT_W-1:0]  left_literal;
    logic [LIT_W-1:0]  right_literal;
  } item_t;

  typedef struct packed {
    logic [LIT_W-1:0]  result_literal;
    logic              created;
    logic [LIT_W-1:0]  child_a_literal;
    logic [LIT_W-1:0]  child_b_literal;
    logic [1:0]        status;
    logic              constant_was_used;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP
  } state_t;

endpackage

// ----- rtl/core/aigs_table.sv -----
// Hash table memory: one write port, one registered read port.
module aigs_table #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  aigs_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output aigs_pkg::entry_t  rdata
);

  aigs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/aig_and_node_strash_unit.sv -----
// Top level: AIG node builder with structural hashing over a probed table.
//
// Usage: drive item and pulse start while busy is low; the item is taken at
// that edge. Exactly one result beat follows, shown on result for one cycle
// with done high; the receiver cannot stall, so take it in that cycle.
// A primary input, a simplified AND, or an AND with hashing disabled gives
// its result in the cycle after acceptance and busy stays low.
// A hashed AND computes the home slot (in the accept cycle when TABLE_ENTRIES
// is a power of two, else a reciprocal-multiply remainder in partial-product,
// quotient and remainder steps), then probes the table with linear probing:
// each probe passes through a read state that addresses the table and a
// compare state on its registered read. A miss writes the new entry in the
// compare cycle unless the node or table limit is reached.
// Reset: control registers return to their reset values, then a clearing
// pass writes every table entry invalid, one entry per cycle, with busy high.
// Configuration writes over APB are taken anytime.
// Registers: 0x0 local_simplify_enable, 0x4 hashing_enable (bit 0).
module aig_and_node_strash_unit #(
  parameter int MAX_NODES     = 65536,
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  aigs_pkg::item_t   item,
  output logic              done,
  output aigs_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = $clog2(TABLE_ENTRIES + 1);
  localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << SW));
  localparam int NODE_LIMIT = (MAX_NODES < aigs_pkg::LITERAL_NODE_CAP) ?
                              MAX_NODES : aigs_pkg::LITERAL_NODE_CAP;
  localparam int LW = aigs_pkg::LIT_W;
  localparam int KW = aigs_pkg::KEY_W;
  localparam logic [63:0] RECIP = ((64'd1 << (KW + SW)) + 64'(TABLE_ENTRIES) - 64'd1) /
                                  64'(TABLE_ENTRIES);
  localparam logic [17:0] RECIP_LO = RECIP[17:0];
  localparam logic [16:0] RECIP_HI = RECIP[34:18];

  aigs_pkg::state_t  state, state_next;
  logic [SW-1:0]     slot, slot_next;
  logic [SW-1:0]     probe_cnt, probe_cnt_next;
  logic [SW-1:0]     clr_idx, clr_idx_next;
  logic [5:0]        bit_cnt, bit_cnt_next;
  logic [KW-1:0]     hval, hval_next;
  logic [KW+17:0]    prod_lo, prod_lo_next;
  logic [KW+16:0]    prod_hi, prod_hi_next;
  logic [KW-1:0]     quot, quot_next;
  logic [KW-1:0]     key, key_next;
  logic [LW-1:0]     lit_l, lit_l_next;
  logic [LW-1:0]     lit_r, lit_r_next;
  logic [LW-1:0]     next_node, next_node_next;
  logic              const_flag, const_flag_next;
  logic [EW-1:0]     entries_used, entries_used_next;
  aigs_pkg::result_t res_next;
  logic              done_next;
  logic              simp_en, hash_en;

  logic              mem_we;
  logic [SW-1:0]     mem_waddr;
  aigs_pkg::entry_t  mem_wdata, mem_rdata;

  // Operand decode for the accept cycle.
  logic [LW-2:0]     ln, rn;
  logic              ordered;
  logic [KW-1:0]     key_in, hash_in;
  logic              node_full;
  logic [LW-1:0]     node_lit;

  aigs_table #(.DEPTH(TABLE_ENTRIES), .AW(SW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (slot),
    .rdata (mem_rdata)
  );

  assign busy   = (state != aigs_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign prdata = {31'd0, (paddr[2] == aigs_pkg::REG_HASHING) ? hash_en : simp_en};

  assign ln        = item.left_literal[LW-1:1];
  assign rn        = item.right_literal[LW-1:1];
  assign ordered   = (ln < rn);
  assign key_in    = ordered ? {item.left_literal, item.right_literal}
                             : {item.right_literal, item.left_literal};
  assign hash_in   = key_in ^ (key_in >> 13) ^ (key_in >> 27);
  assign node_full = (next_node >= LW'(NODE_LIMIT));
  assign node_lit  = {next_node[LW-2:0], 1'b0};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      simp_en <= 1'b1;
      hash_en <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == aigs_pkg::REG_HASHING) begin
        hash_en <= pwdata[0];
      end else begin
        simp_en <= pwdata[0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      aigs_pkg::ST_CLEAR: begin
        if (clr_idx == SW'(TABLE_ENTRIES - 1)) state_next = aigs_pkg::ST_IDLE;
      end
      aigs_pkg::ST_IDLE: begin
        if (start && item.command == aigs_pkg::CMD_AND && hash_en &&
            !(simp_en && (ln == '0 || rn == '0 || ln == rn))) begin
          state_next = IS_POW2 ? aigs_pkg::ST_READ : aigs_pkg::ST_HASH;
        end
      end
      aigs_pkg::ST_HASH: begin
        if (bit_cnt == '0) state_next = aigs_pkg::ST_READ;
      end
      aigs_pkg::ST_READ: state_next = aigs_pkg::ST_CMP;
      aigs_pkg::ST_CMP: begin
        if (mem_rdata.valid && mem_rdata.key != key &&
            probe_cnt != SW'(TABLE_ENTRIES - 1)) begin
          state_next = aigs_pkg::ST_READ;
        end else begin
          state_next = aigs_pkg::ST_IDLE;
        end
      end
      default: state_next = aigs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    slot_next         = slot;
    probe_cnt_next    = probe_cnt;
    clr_idx_next      = clr_idx;
    bit_cnt_next      = bit_cnt;
    hval_next         = hval;
    prod_lo_next      = prod_lo;
    prod_hi_next      = prod_hi;
    quot_next         = quot;
    key_next          = key;
    lit_l_next        = lit_l;
    lit_r_next        = lit_r;
    next_node_next    = next_node;
    const_flag_next   = const_flag;
    entries_used_next = entries_used;
    res_next          = result;
    done_next         = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = slot;
    mem_wdata         = '{valid: 1'b1, key: key, node: next_node[LW-2:0]};

    case (state)
      aigs_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        mem_wdata    = '{valid: 1'b0, key: '0, node: '0};
        clr_idx_next = clr_idx + 1'b1;
      end
      aigs_pkg::ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          res_next  = '0;
          if (item.command == aigs_pkg::CMD_INPUT) begin
            if (node_full) begin
              res_next.status = aigs_pkg::STATUS_NODE_FULL;
            end else begin
              res_next.result_literal = node_lit;
              res_next.created        = 1'b1;
              next_node_next          = next_node + 1'b1;
            end
          end else if (simp_en && ln == '0) begin
            if (!item.left_literal[0]) const_flag_next = 1'b1;
            else res_next.result_literal = item.right_literal;
          end else if (simp_en && rn == '0) begin
            if (!item.right_literal[0]) const_flag_next = 1'b1;
            else res_next.result_literal = item.left_literal;
          end else if (simp_en && item.left_literal == item.right_literal) begin
            res_next.result_literal = item.left_literal;
          end else if (simp_en && ln == rn) begin
            const_flag_next = 1'b1;
          end else if (!hash_en) begin
            if (node_full) begin
              res_next.status = aigs_pkg::STATUS_NODE_FULL;
            end else begin
              res_next.result_literal  = node_lit;
              res_next.created         = 1'b1;
              res_next.child_a_literal = item.left_literal;
              res_next.child_b_literal = item.right_literal;
              next_node_next           = next_node + 1'b1;
            end
          end else begin
            // Hashed path: hold the result until the probe ends.
            done_next      = 1'b0;
            res_next       = result;
            key_next       = key_in;
            lit_l_next     = item.left_literal;
            lit_r_next     = item.right_literal;
            hval_next      = hash_in;
            probe_cnt_next = '0;
            bit_cnt_next   = 6'd2;
            slot_next      = IS_POW2 ? hash_in[SW-1:0] : '0;
          end
          res_next.constant_was_used = const_flag_next;
        end
      end
      aigs_pkg::ST_HASH: begin
        // Remainder by reciprocal multiply: partial products, quotient, remainder.
        case (bit_cnt)
          6'd2: begin
            prod_lo_next = (KW+18)'(hval) * (KW+18)'(RECIP_LO);
            prod_hi_next = (KW+17)'(hval) * (KW+17)'(RECIP_HI);
          end
          6'd1: begin
            quot_next = KW'(({prod_hi, 18'd0} + (KW+35)'(prod_lo)) >> (KW + SW));
          end
          default: begin
            slot_next = SW'(hval - KW'(quot * KW'(TABLE_ENTRIES)));
          end
        endcase
        bit_cnt_next = bit_cnt - 1'b1;
      end
      aigs_pkg::ST_READ: begin
      end
      aigs_pkg::ST_CMP: begin
        res_next = '0;
        res_next.constant_was_used = const_flag;
        if (mem_rdata.valid && mem_rdata.key == key) begin
          done_next = 1'b1;
          res_next.result_literal = {mem_rdata.node, 1'b0};
        end else if (mem_rdata.valid && probe_cnt != SW'(TABLE_ENTRIES - 1)) begin
          // Advance to the next slot.
          slot_next      = (slot == SW'(TABLE_ENTRIES - 1)) ? '0 : slot + 1'b1;
          probe_cnt_next = probe_cnt + 1'b1;
          res_next       = result;
        end else begin
          done_next = 1'b1;
          if (node_full) begin
            res_next.status = aigs_pkg::STATUS_NODE_FULL;
          end else if (mem_rdata.valid || entries_used >= EW'(TABLE_ENTRIES)) begin
            res_next.status = aigs_pkg::STATUS_TABLE_FULL;
          end else begin
            mem_we                   = 1'b1;
            entries_used_next        = entries_used + 1'b1;
            next_node_next           = next_node + 1'b1;
            res_next.result_literal  = node_lit;
            res_next.created         = 1'b1;
            res_next.child_a_literal = lit_l;
            res_next.child_b_literal = lit_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= aigs_pkg::ST_CLEAR;
      clr_idx      <= '0;
      next_node    <= LW'(1);
      const_flag   <= 1'b0;
      entries_used <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      next_node    <= next_node_next;
      const_flag   <= const_flag_next;
      entries_used <= entries_used_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    slot      <= slot_next;
    probe_cnt <= probe_cnt_next;
    bit_cnt   <= bit_cnt_next;
    hval      <= hval_next;
    prod_lo   <= prod_lo_next;
    prod_hi   <= prod_hi_next;
    quot      <= quot_next;
    key       <= key_next;
    lit_l     <= lit_l_next;
    lit_r     <= lit_r_next;
    result    <= res_next;
  end

endmodule

// ----- rtl/core/aigs_checker.sv -----
// Port-level checker for the strash unit, bound to the top level.
`include "aig_and_node_strash_unit_defines.svh"

module aigs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input aigs_pkg::result_t result
);

  `AIGS_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `AIGS_ASSERT_IMP(a_status_code, done, result.status != 2'd3)
  `AIGS_ASSERT_IMP(a_created_even, done && result.created,
                   !result.result_literal[0] && result.status == aigs_pkg::STATUS_OK)
  `AIGS_ASSERT_IMP(a_error_clean, done && result.status != aigs_pkg::STATUS_OK,
                   result.result_literal == '0 && !result.created)

endmodule

bind aig_and_node_strash_unit aigs_checker u_aigs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
